### hw/rtl/pipgeo_pkg.sv
// Package with the shared types and constants of the point-in-polygon geofence.
package pipgeo_pkg;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_BOX    = 11'b000_0000_0010,
      ST_BOXCHK = 11'b000_0000_0100,
      ST_LOADA  = 11'b000_0000_1000,
      ST_LATCHA = 11'b000_0001_0000,
      ST_EDGERD = 11'b000_0010_0000,
      ST_SETUP  = 11'b000_0100_0000,
      ST_ABSV   = 11'b000_1000_0000,
      ST_MUL    = 11'b001_0000_0000,
      ST_CHK    = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   typedef logic [4:0] step_type;

   localparam step_type STEP_DV0  = 5'd0;
   localparam step_type STEP_DV1  = 5'd1;
   localparam step_type STEP_D00  = 5'd2;
   localparam step_type STEP_D01  = 5'd3;
   localparam step_type STEP_D10  = 5'd4;
   localparam step_type STEP_D11  = 5'd5;
   localparam step_type STEP_CR0  = 5'd6;
   localparam step_type STEP_CR1  = 5'd7;
   localparam step_type STEP_GAP  = 5'd8;
   localparam step_type STEP_ABS  = 5'd9;
   localparam step_type STEP_C0   = 5'd10;
   localparam step_type STEP_C1   = 5'd11;
   localparam step_type STEP_C2   = 5'd12;
   localparam step_type STEP_C3   = 5'd13;
   localparam step_type STEP_T0   = 5'd14;
   localparam step_type STEP_T1   = 5'd15;
   localparam step_type STEP_T2   = 5'd16;
   localparam step_type STEP_T3   = 5'd17;
   localparam step_type STEP_LAST = 5'd18;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic CSR_VERTEX_COUNT   = 1'b0;
   localparam logic CSR_EDGE_TOLERANCE = 1'b1;

   localparam logic [15:0] TOL_RESET = 16'd256;
   localparam int MIN_POLY_VERTS = 2;

endpackage

### hw/rtl/pipgeo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pipgeo_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/point_in_polygon_geofence.sv
// Top level of the point-in-polygon geofence with edge tolerance.
//
// A req beat with op write stores one vertex; it produces no rsp beat.
// A req beat with op query tests a point and produces exactly one rsp beat
// carrying inside_res and near_edge. The csr channel writes the vertex count
// and the edge tolerance and is always ready; the user must write it only
// while idle, as the block itself does not enforce this. One query is worked
// on at a time. A query (vertex count clipped to MAX_VERTICES) first makes a
// bounding box pass over the vertex memories, then works each edge in turn,
// running 16 products through the single shared multiplier plus setup and
// compare. A query stops at the first near edge and goes straight to its
// result when fewer than two vertices are in use or the box rejects the point.
// The result sits in an output register; the next req beat is taken while
// it waits, and a finished query holds until that register is free when the
// receiver stalls. Synchronous reset empties the output register, sets the
// vertex count to 0 and the tolerance to 256; vertex memories keep contents.
module point_in_polygon_geofence #(
   parameter int MAX_VERTICES = 32,
   parameter int COORD_WIDTH  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [4:0]             req_vertex_index,
   input  logic [COORD_WIDTH-1:0] req_coord_x,
   input  logic [COORD_WIDTH-1:0] req_coord_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_inside_res,
   output logic                   rsp_near_edge,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [15:0]            csr_data
);

   localparam int W  = COORD_WIDTH;
   localparam int W2 = W + 2;
   localparam int D  = W + 1;
   localparam int M  = D + 1;
   localparam int M2 = 2 * M;
   localparam int M4 = 4 * M;
   localparam int S  = 2 * D + 1;
   localparam int S1 = S + 1;
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   function automatic logic [D-1:0] mag_of(input logic signed [D-1:0] v);
      return v[D-1] ? D'(-v) : D'(v);
   endfunction

   pipgeo_pkg::state_type state_ff, state_in;
   logic [5:0]            vcount_ff, vcount_in;
   logic [15:0]           tol_ff, tol_in;
   logic [31:0]           tol2_ff, tol2_in;
   logic signed [W-1:0]   px_ff, px_in, py_ff, py_in;
   logic [CW-1:0]         ptr_ff, ptr_in, ei_ff, ei_in;
   logic                  rdv_ff, rdv_in, first_ff, first_in;
   logic signed [W-1:0]   minx_ff, minx_in, maxx_ff, maxx_in;
   logic signed [W-1:0]   miny_ff, miny_in, maxy_ff, maxy_in;
   logic signed [W-1:0]   ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [D-1:0]   dxb_ff, dxb_in, dyb_ff, dyb_in;
   logic signed [D-1:0]   e0x_ff, e0x_in, e0y_ff, e0y_in, e1x_ff, e1x_in, e1y_ff, e1y_in;
   logic [D-1:0]          mdx_ff, mdx_in, mdy_ff, mdy_in;
   logic [D-1:0]          m0x_ff, m0x_in, m0y_ff, m0y_in, m1x_ff, m1x_in, m1y_ff, m1y_in;
   logic                  s1_ff, s1_in, s2_ff, s2_in;
   pipgeo_pkg::step_type  cnt_ff, cnt_in, tag_ff, tag_in;
   logic                  pv_ff, pv_in;
   logic [M2-1:0]         prod_ff, prod_in;
   logic [S-1:0]          dv_ff, dv_in, d0_ff, d0_in, d1_ff, d1_in;
   logic signed [S1-1:0]  cr_ff, cr_in;
   logic [S-1:0]          crmag_ff, crmag_in;
   logic [M4-1:0]         accc_ff, accc_in, acct_ff, acct_in;
   logic                  odd_ff, odd_in;
   logic                  fin_inside_ff, fin_inside_in, fin_near_ff, fin_near_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_inside_ff, rsp_inside_in, rsp_near_ff, rsp_near_in;

   logic [CW-1:0]         n_cnt, ei_nx, j_idx;
   logic [AW-1:0]         slot;
   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [W-1:0]          rdx, rdy;
   logic signed [W-1:0]   vx, vy;
   logic [M-1:0]          mul_a, mul_b;
   logic                  issue;
   logic [M2-1:0]         prod_w, crw, dvw, tw;
   logic [M4-1:0]         pw;
   logic signed [S1-1:0]  prod_s;
   logic signed [W2-1:0]  tolw, pxw, pyw;
   logic                  outside, close, in_span, swapped, crosses, odd_nx;
   logic signed [W-1:0]   lo_y, hi_y;
   logic [S-1:0]          tol2e;
   logic                  req_acc;

   assign n_cnt = (int'(vcount_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_ff);
   assign ei_nx = ei_ff + CW'(1);
   assign j_idx = (ei_nx == n_cnt) ? '0 : ei_nx;

   always_comb begin
      slot = '0;
      for (int k = 0; k < 32; k++) begin
         if (req_vertex_index == 5'(k)) begin
            slot = AW'(k % MAX_VERTICES);
         end
      end
   end

   pipgeo_ram #(.WIDTH(W), .DEPTH(MAX_VERTICES)) u_ram_x (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot),
      .wr_data (req_coord_x),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rdx)
   );

   pipgeo_ram #(.WIDTH(W), .DEPTH(MAX_VERTICES)) u_ram_y (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot),
      .wr_data (req_coord_y),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rdy)
   );

   assign vx = $signed(rdx);
   assign vy = $signed(rdy);

   assign crw = M2'(crmag_ff);
   assign dvw = M2'(dv_ff);
   assign tw  = M2'(tol2_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      issue = 1'b0;
      unique case (cnt_ff)
         pipgeo_pkg::STEP_DV0: begin
            mul_a = M'(mdx_ff); mul_b = M'(mdx_ff); issue = 1'b1;
         end
         pipgeo_pkg::STEP_DV1: begin
            mul_a = M'(mdy_ff); mul_b = M'(mdy_ff); issue = 1'b1;
         end
         pipgeo_pkg::STEP_D00: begin
            mul_a = M'(m0x_ff); mul_b = M'(m0x_ff); issue = 1'b1;
         end
         pipgeo_pkg::STEP_D01: begin
            mul_a = M'(m0y_ff); mul_b = M'(m0y_ff); issue = 1'b1;
         end
         pipgeo_pkg::STEP_D10: begin
            mul_a = M'(m1x_ff); mul_b = M'(m1x_ff); issue = 1'b1;
         end
         pipgeo_pkg::STEP_D11: begin
            mul_a = M'(m1y_ff); mul_b = M'(m1y_ff); issue = 1'b1;
         end
         pipgeo_pkg::STEP_CR0: begin
            mul_a = M'(mdy_ff); mul_b = M'(m0x_ff); issue = 1'b1;
         end
         pipgeo_pkg::STEP_CR1: begin
            mul_a = M'(mdx_ff); mul_b = M'(m0y_ff); issue = 1'b1;
         end
         pipgeo_pkg::STEP_C0: begin
            mul_a = crw[M-1:0]; mul_b = crw[M-1:0]; issue = 1'b1;
         end
         pipgeo_pkg::STEP_C1: begin
            mul_a = crw[M-1:0]; mul_b = crw[M2-1:M]; issue = 1'b1;
         end
         pipgeo_pkg::STEP_C2: begin
            mul_a = crw[M2-1:M]; mul_b = crw[M-1:0]; issue = 1'b1;
         end
         pipgeo_pkg::STEP_C3: begin
            mul_a = crw[M2-1:M]; mul_b = crw[M2-1:M]; issue = 1'b1;
         end
         pipgeo_pkg::STEP_T0: begin
            mul_a = tw[M-1:0]; mul_b = dvw[M-1:0]; issue = 1'b1;
         end
         pipgeo_pkg::STEP_T1: begin
            mul_a = tw[M-1:0]; mul_b = dvw[M2-1:M]; issue = 1'b1;
         end
         pipgeo_pkg::STEP_T2: begin
            mul_a = tw[M2-1:M]; mul_b = dvw[M-1:0]; issue = 1'b1;
         end
         pipgeo_pkg::STEP_T3: begin
            mul_a = tw[M2-1:M]; mul_b = dvw[M2-1:M]; issue = 1'b1;
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   assign prod_w = mul_a * mul_b;
   assign pw     = M4'(prod_ff);
   assign prod_s = $signed({1'b0, prod_ff[S-1:0]});

   assign tolw    = $signed(W2'(tol_ff));
   assign pxw     = W2'(px_ff);
   assign pyw     = W2'(py_ff);
   assign outside = (pxw < W2'(minx_ff) - tolw) || (pxw > W2'(maxx_ff) + tolw) ||
                    (pyw < W2'(miny_ff) - tolw) || (pyw > W2'(maxy_ff) + tolw);

   assign tol2e   = S'(tol2_ff);
   assign close   = (d0_ff < tol2e) || (d1_ff < tol2e) ||
                    ((accc_ff < acct_ff) && (d0_ff < dv_ff) && (d1_ff < dv_ff));
   assign swapped = ay_ff > by_ff;
   assign lo_y    = swapped ? by_ff : ay_ff;
   assign hi_y    = swapped ? ay_ff : by_ff;
   assign in_span = (py_ff >= lo_y) && (py_ff < hi_y);
   assign crosses = in_span && (cr_ff != '0) && (swapped ? !cr_ff[S1-1] : cr_ff[S1-1]);
   assign odd_nx  = odd_ff ^ crosses;

   assign req_ready = (state_ff == pipgeo_pkg::ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      vcount_in     = vcount_ff;
      tol_in        = tol_ff;
      tol2_in       = tol2_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      ptr_in        = ptr_ff;
      ei_in         = ei_ff;
      rdv_in        = 1'b0;
      first_in      = first_ff;
      minx_in       = minx_ff;
      maxx_in       = maxx_ff;
      miny_in       = miny_ff;
      maxy_in       = maxy_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      dxb_in        = dxb_ff;
      dyb_in        = dyb_ff;
      e0x_in        = e0x_ff;
      e0y_in        = e0y_ff;
      e1x_in        = e1x_ff;
      e1y_in        = e1y_ff;
      mdx_in        = mdx_ff;
      mdy_in        = mdy_ff;
      m0x_in        = m0x_ff;
      m0y_in        = m0y_ff;
      m1x_in        = m1x_ff;
      m1y_in        = m1y_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      cnt_in        = cnt_ff;
      tag_in        = tag_ff;
      pv_in         = 1'b0;
      prod_in       = prod_ff;
      dv_in         = dv_ff;
      d0_in         = d0_ff;
      d1_in         = d1_ff;
      cr_in         = cr_ff;
      crmag_in      = crmag_ff;
      accc_in       = accc_ff;
      acct_in       = acct_ff;
      odd_in        = odd_ff;
      fin_inside_in = fin_inside_ff;
      fin_near_in   = fin_near_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_inside_in = rsp_inside_ff;
      rsp_near_in   = rsp_near_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      if (csr_valid) begin
         unique case (csr_index)
            pipgeo_pkg::CSR_VERTEX_COUNT:   vcount_in = csr_data[5:0];
            pipgeo_pkg::CSR_EDGE_TOLERANCE: tol_in    = csr_data;
            default:                        tol_in    = tol_ff;
         endcase
      end

      if (pv_ff) begin
         unique case (tag_ff)
            pipgeo_pkg::STEP_DV0: dv_in = S'(prod_ff);
            pipgeo_pkg::STEP_DV1: dv_in = dv_ff + S'(prod_ff);
            pipgeo_pkg::STEP_D00: d0_in = S'(prod_ff);
            pipgeo_pkg::STEP_D01: d0_in = d0_ff + S'(prod_ff);
            pipgeo_pkg::STEP_D10: d1_in = S'(prod_ff);
            pipgeo_pkg::STEP_D11: d1_in = d1_ff + S'(prod_ff);
            pipgeo_pkg::STEP_CR0: cr_in = s1_ff ? -prod_s : prod_s;
            pipgeo_pkg::STEP_CR1: cr_in = s2_ff ? cr_ff + prod_s : cr_ff - prod_s;
            pipgeo_pkg::STEP_C0:  accc_in = pw;
            pipgeo_pkg::STEP_C1:  accc_in = accc_ff + (pw << M);
            pipgeo_pkg::STEP_C2:  accc_in = accc_ff + (pw << M);
            pipgeo_pkg::STEP_C3:  accc_in = accc_ff + (pw << M2);
            pipgeo_pkg::STEP_T0:  acct_in = pw;
            pipgeo_pkg::STEP_T1:  acct_in = acct_ff + (pw << M);
            pipgeo_pkg::STEP_T2:  acct_in = acct_ff + (pw << M);
            pipgeo_pkg::STEP_T3:  acct_in = acct_ff + (pw << M2);
            default:              acct_in = acct_ff;
         endcase
      end

      if (rdv_ff) begin
         first_in = 1'b0;
         if (first_ff) begin
            minx_in = vx;
            maxx_in = vx;
            miny_in = vy;
            maxy_in = vy;
         end else begin
            if (vx > maxx_ff) maxx_in = vx;
            if (vx < minx_ff) minx_in = vx;
            if (vy > maxy_ff) maxy_in = vy;
            if (vy < miny_ff) miny_in = vy;
         end
      end

      unique case (state_ff)
         pipgeo_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_op == pipgeo_pkg::OP_WRITE) begin
                  ram_we = 1'b1;
               end else begin
                  px_in   = $signed(req_coord_x);
                  py_in   = $signed(req_coord_y);
                  tol2_in = tol_ff * tol_ff;
                  if (int'(n_cnt) < pipgeo_pkg::MIN_POLY_VERTS) begin
                     fin_inside_in = 1'b0;
                     fin_near_in   = 1'b0;
                     state_in      = pipgeo_pkg::ST_FINISH;
                  end else begin
                     ptr_in   = '0;
                     first_in = 1'b1;
                     state_in = pipgeo_pkg::ST_BOX;
                  end
               end
            end
         end
         pipgeo_pkg::ST_BOX: begin
            if (ptr_ff != n_cnt) begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff + CW'(1);
               rdv_in    = 1'b1;
            end else begin
               state_in = pipgeo_pkg::ST_BOXCHK;
            end
         end
         pipgeo_pkg::ST_BOXCHK: begin
            if (outside) begin
               fin_inside_in = 1'b0;
               fin_near_in   = 1'b0;
               state_in      = pipgeo_pkg::ST_FINISH;
            end else begin
               state_in = pipgeo_pkg::ST_LOADA;
            end
         end
         pipgeo_pkg::ST_LOADA: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            ei_in     = '0;
            odd_in    = 1'b0;
            state_in  = pipgeo_pkg::ST_LATCHA;
         end
         pipgeo_pkg::ST_LATCHA: begin
            ax_in     = vx;
            ay_in     = vy;
            ram_re    = 1'b1;
            ram_raddr = j_idx[AW-1:0];
            state_in  = pipgeo_pkg::ST_SETUP;
         end
         pipgeo_pkg::ST_EDGERD: begin
            ram_re    = 1'b1;
            ram_raddr = j_idx[AW-1:0];
            state_in  = pipgeo_pkg::ST_SETUP;
         end
         pipgeo_pkg::ST_SETUP: begin
            bx_in    = vx;
            by_in    = vy;
            dxb_in   = D'(vx) - D'(ax_ff);
            dyb_in   = D'(vy) - D'(ay_ff);
            e0x_in   = D'(px_ff) - D'(ax_ff);
            e0y_in   = D'(py_ff) - D'(ay_ff);
            e1x_in   = D'(px_ff) - D'(vx);
            e1y_in   = D'(py_ff) - D'(vy);
            state_in = pipgeo_pkg::ST_ABSV;
         end
         pipgeo_pkg::ST_ABSV: begin
            mdx_in   = mag_of(dxb_ff);
            mdy_in   = mag_of(dyb_ff);
            m0x_in   = mag_of(e0x_ff);
            m0y_in   = mag_of(e0y_ff);
            m1x_in   = mag_of(e1x_ff);
            m1y_in   = mag_of(e1y_ff);
            s1_in    = dyb_ff[D-1] ^ e0x_ff[D-1];
            s2_in    = dxb_ff[D-1] ^ e0y_ff[D-1];
            cnt_in   = '0;
            state_in = pipgeo_pkg::ST_MUL;
         end
         pipgeo_pkg::ST_MUL: begin
            pv_in   = issue;
            tag_in  = cnt_ff;
            prod_in = prod_w;
            if (cnt_ff == pipgeo_pkg::STEP_ABS) begin
               crmag_in = cr_ff[S1-1] ? S'(-cr_ff) : S'(cr_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == pipgeo_pkg::STEP_LAST) begin
               state_in = pipgeo_pkg::ST_CHK;
            end
         end
         pipgeo_pkg::ST_CHK: begin
            if (close) begin
               fin_inside_in = 1'b1;
               fin_near_in   = 1'b1;
               state_in      = pipgeo_pkg::ST_FINISH;
            end else begin
               odd_in = odd_nx;
               if (ei_nx == n_cnt) begin
                  fin_inside_in = odd_nx;
                  fin_near_in   = 1'b0;
                  state_in      = pipgeo_pkg::ST_FINISH;
               end else begin
                  ei_in    = ei_nx;
                  ax_in    = bx_ff;
                  ay_in    = by_ff;
                  state_in = pipgeo_pkg::ST_EDGERD;
               end
            end
         end
         pipgeo_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = fin_inside_ff;
               rsp_near_in   = fin_near_ff;
               state_in      = pipgeo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pipgeo_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pipgeo_pkg::ST_IDLE;
         vcount_ff    <= '0;
         tol_ff       <= pipgeo_pkg::TOL_RESET;
         rdv_ff       <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         tol_ff       <= tol_in;
         rdv_ff       <= rdv_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tol2_ff       <= tol2_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      ptr_ff        <= ptr_in;
      ei_ff         <= ei_in;
      first_ff      <= first_in;
      minx_ff       <= minx_in;
      maxx_ff       <= maxx_in;
      miny_ff       <= miny_in;
      maxy_ff       <= maxy_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      dxb_ff        <= dxb_in;
      dyb_ff        <= dyb_in;
      e0x_ff        <= e0x_in;
      e0y_ff        <= e0y_in;
      e1x_ff        <= e1x_in;
      e1y_ff        <= e1y_in;
      mdx_ff        <= mdx_in;
      mdy_ff        <= mdy_in;
      m0x_ff        <= m0x_in;
      m0y_ff        <= m0y_in;
      m1x_ff        <= m1x_in;
      m1y_ff        <= m1y_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      cnt_ff        <= cnt_in;
      tag_ff        <= tag_in;
      prod_ff       <= prod_in;
      dv_ff         <= dv_in;
      d0_ff         <= d0_in;
      d1_ff         <= d1_in;
      cr_ff         <= cr_in;
      crmag_ff      <= crmag_in;
      accc_ff       <= accc_in;
      acct_ff       <= acct_in;
      odd_ff        <= odd_in;
      fin_inside_ff <= fin_inside_in;
      fin_near_ff   <= fin_near_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_near_ff   <= rsp_near_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_near_edge  = rsp_near_ff;

endmodule

### hw/rtl/pipgeo_chk.sv
// Port-level checker for the geofence top level, with its bind statement.
module pipgeo_chk #(
   parameter int COORD_WIDTH = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_op,
   input logic [4:0]             req_vertex_index,
   input logic [COORD_WIDTH-1:0] req_coord_x,
   input logic [COORD_WIDTH-1:0] req_coord_y,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_inside_res,
   input logic                   rsp_near_edge,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic                   csr_index,
   input logic [15:0]            csr_data
);

   // A result beat stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // A point found near an edge is always reported inside.
   a_near_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_near_edge |-> rsp_inside_res)
      else $error("near edge without inside");

   // A vertex write never produces a result beat.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == pipgeo_pkg::OP_WRITE) && !rsp_valid
      |=> !rsp_valid)
      else $error("result beat after a vertex write");

endmodule

bind point_in_polygon_geofence pipgeo_chk #(.COORD_WIDTH(COORD_WIDTH)) u_pipgeo_chk (.*);
